// ===== hw/rtl/dtoi_pkg.sv =====
`timescale 1ns / 1ps

package dtoi_pkg;

    // Parse phase of the current string
    typedef enum logic [2:0] {
        PH_LEAD   = 3'd0,
        PH_SIGN   = 3'd1,
        PH_DIGITS = 3'd2,
        PH_TRAIL  = 3'd3,
        PH_IGNORE = 3'd4,
        PH_NODIG  = 3'd5
    } phase_t;

    // Result status codes
    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_SYNTAX      = 2'd1;
    localparam logic [1:0] STATUS_RANGE       = 2'd2;
    localparam logic [1:0] STATUS_UNSUPPORTED = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESULT_BYTES = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TERMINATOR   = 1'b1;

    localparam logic [3:0] RESULT_BYTES_RESET = 4'd4;
    localparam logic [7:0] TERMINATOR_RESET   = 8'd0;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    // Magnitude cap: 2^31
    localparam logic [35:0] MAG_CAP = 36'h0_8000_0000;

    typedef struct packed {
        logic [3:0] result_bytes;
        logic [7:0] terminator_char;
    } cfg_t;

    function automatic logic is_blank(input logic [7:0] c);
        is_blank = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= 8'h30) && (c <= 8'h39);
    endfunction

endpackage

// ===== hw/rtl/dtoi_char_if.sv =====
`timescale 1ns / 1ps

interface dtoi_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

// ===== hw/rtl/dtoi_result_if.sv =====
`timescale 1ns / 1ps

interface dtoi_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic        [1:0]  status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

// ===== hw/rtl/dtoi_core.sv =====
`timescale 1ns / 1ps

module dtoi_core
    import dtoi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         ch,
    input  cfg_t               cfg,
    output logic signed [31:0] res_value,
    output logic [1:0]         res_status
);

    phase_t      phase_reg, phase_next;
    logic        any_reg, any_next;
    logic        neg_reg, neg_next;
    logic [31:0] mag_reg, mag_next;
    logic        ovf_reg, ovf_next;
    logic        junk_reg, junk_next;

    // Accumulator candidate: mag * 10 + digit
    logic [35:0] acc_sum;
    logic        take_digit;

    assign acc_sum = {1'b0, mag_reg, 3'b000} + {3'b000, mag_reg, 1'b0}
                     + {32'd0, ch[3:0] - CH_ZERO[3:0]};

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (ch == CH_NUL)
        begin
            phase_next = PH_LEAD;
        end
        else
        begin
            case (phase_reg)
                PH_LEAD:
                begin
                    if (is_blank(ch))
                        phase_next = PH_LEAD;
                    else if (ch == CH_PLUS || ch == CH_MINUS)
                        phase_next = PH_SIGN;
                    else if (is_digit(ch))
                        phase_next = PH_DIGITS;
                    else
                        phase_next = PH_NODIG;
                end
                PH_SIGN:
                begin
                    phase_next = is_digit(ch) ? PH_DIGITS : PH_NODIG;
                end
                PH_DIGITS:
                begin
                    if (is_digit(ch))
                        phase_next = PH_DIGITS;
                    else if (ch == cfg.terminator_char)
                        phase_next = PH_IGNORE;
                    else if (is_blank(ch))
                        phase_next = PH_TRAIL;
                    else
                        phase_next = PH_IGNORE;
                end
                PH_TRAIL:
                begin
                    if (ch == cfg.terminator_char || !is_blank(ch))
                        phase_next = PH_IGNORE;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Datapath updates that follow the phase
    always_comb
    begin
        any_next   = any_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        ovf_next   = ovf_reg;
        junk_next  = junk_reg;
        take_digit = 1'b0;
        if (ch == CH_NUL)
        begin
            any_next  = 1'b0;
            neg_next  = 1'b0;
            mag_next  = '0;
            ovf_next  = 1'b0;
            junk_next = 1'b0;
        end
        else
        begin
            any_next = 1'b1;
            case (phase_reg)
                PH_LEAD:
                begin
                    if (!is_blank(ch) && (ch == CH_PLUS || ch == CH_MINUS))
                        neg_next = (ch == CH_MINUS);
                    else if (is_digit(ch))
                        take_digit = 1'b1;
                end
                PH_SIGN, PH_DIGITS:
                begin
                    take_digit = is_digit(ch);
                    if (phase_reg == PH_DIGITS && !is_digit(ch)
                        && ch != cfg.terminator_char && !is_blank(ch))
                        junk_next = 1'b1;
                end
                PH_TRAIL:
                begin
                    if (ch != cfg.terminator_char && !is_blank(ch))
                        junk_next = 1'b1;
                end
                default:
                begin
                    take_digit = 1'b0;
                end
            endcase
            // Sticky overflow: stop accumulating past 2^31
            if (take_digit && !ovf_reg)
            begin
                if (acc_sum > MAG_CAP)
                    ovf_next = 1'b1;
                else
                    mag_next = acc_sum[31:0];
            end
        end
    end

    // Parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            any_reg   <= 1'b0;
            neg_reg   <= 1'b0;
            mag_reg   <= '0;
            ovf_reg   <= 1'b0;
            junk_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            any_reg   <= any_next;
            neg_reg   <= neg_next;
            mag_reg   <= mag_next;
            ovf_reg   <= ovf_next;
            junk_reg  <= junk_next;
        end
    end

    // End-of-string result from the current state
    logic        have_digits;
    logic        size_ok;
    logic [32:0] limit;

    always_comb
    begin
        have_digits = (phase_reg inside {PH_DIGITS, PH_TRAIL, PH_IGNORE});
        size_ok     = 1'b1;
        case (cfg.result_bytes)
            4'd1:    limit = 33'd128;
            4'd2:    limit = 33'd32768;
            4'd4:    limit = 33'h0_8000_0000;
            default:
            begin
                limit   = 33'h0_8000_0000;
                size_ok = 1'b0;
            end
        endcase
        if (!neg_reg)
            limit = limit - 33'd1;

        res_value = '0;
        if (!any_reg || !have_digits)
            res_status = STATUS_SYNTAX;
        else if (!size_ok)
            res_status = STATUS_UNSUPPORTED;
        else if (ovf_reg || ({1'b0, mag_reg} > limit))
            res_status = STATUS_RANGE;
        else if (junk_reg)
            res_status = STATUS_SYNTAX;
        else
        begin
            res_status = STATUS_OK;
            res_value  = neg_reg ? -$signed(mag_reg) : $signed(mag_reg);
        end
    end

endmodule

// ===== hw/rtl/decimal_text_to_integer_top.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Payload                         Transaction
// chars     in   ch[7:0]                         one character, zero ends the string
// results   out  value[31:0] signed, status[1:0] one per string, on the zero character
// cfg_*     in   cfg_index[0], cfg_data[7:0]     register write when cfg_we is high
//
// One character per cycle unless a zero waits on a stalled result; the accumulator
// update (mag*10 + digit and the 2^31 compare) sits between input register and state.
// A result is registered when its zero character leaves the input register.
// Reset clears the parse state and loads result_bytes = 4, terminator = 0.
// A stalled result holds the next zero character, and the input stalls behind it.

module decimal_text_to_integer_top
    import dtoi_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    dtoi_char_if.sink              chars,
    dtoi_result_if.source          results,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t               cfg_reg;
    logic [7:0]         ch_reg;
    logic               ch_valid_reg;
    logic               out_valid_reg;
    logic signed [31:0] value_reg;
    logic [1:0]         status_reg;

    logic               is_end;
    logic               advance;
    logic               chars_fire;
    logic signed [31:0] res_value;
    logic [1:0]         res_status;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.result_bytes    <= RESULT_BYTES_RESET;
            cfg_reg.terminator_char <= TERMINATOR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RESULT_BYTES: cfg_reg.result_bytes    <= cfg_data[3:0];
                CFG_TERMINATOR:   cfg_reg.terminator_char <= cfg_data;
                default:          cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // Handshake: a held character moves on unless it needs a busy output slot
    assign is_end      = (ch_reg == CH_NUL);
    assign advance     = ch_valid_reg && (!is_end || !out_valid_reg || results.ready);
    assign chars.ready = !ch_valid_reg || advance;
    assign chars_fire  = chars.valid && chars.ready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_valid_reg <= 1'b0;
        end
        else if (chars_fire)
        begin
            ch_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            ch_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars_fire)
            ch_reg <= chars.ch;
    end

    dtoi_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .ch         (ch_reg),
        .cfg        (cfg_reg),
        .res_value  (res_value),
        .res_status (res_status)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && is_end)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && is_end)
        begin
            value_reg  <= res_value;
            status_reg <= res_status;
        end
    end

    assign results.valid  = out_valid_reg;
    assign results.value  = value_reg;
    assign results.status = status_reg;

endmodule
